>>> rtl/emsd_pkg.sv
// Shared types, widths and constants for the echo median stuck detector.
package emsd_pkg;

    localparam int DEFAULT_FRAC_BITS = 4;

    localparam int ECHO_W    = 15;
    localparam int SIDE_W    = 12;
    localparam int ELAPSED_W = 8;
    localparam int DIST_W    = 14;
    localparam int THR_W     = 10;
    localparam int LIMIT_W   = 3;
    localparam int IVL_W     = 10;
    localparam int TIME_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam int ECHO_DIV        = 58;
    localparam int ECHO_TIMEOUT_US = 25000;
    localparam int TIMEOUT_CM      = 999;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(48);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);
    localparam logic [IVL_W-1:0]   IVL_RESET   = IVL_W'(500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STUCK_THRESHOLD   = 2'd0,
        CFG_STUCK_LIMIT       = 2'd1,
        CFG_CHECK_INTERVAL_MS = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [THR_W-1:0]   stuck_threshold;
        logic [LIMIT_W-1:0] stuck_limit;
        logic [IVL_W-1:0]   check_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0]    front_dist;
        logic [SIDE_W-1:0]    left_dist;
        logic [SIDE_W-1:0]    right_dist;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 nav_exempt;
    } t_item;

endpackage

>>> rtl/echo_median_stuck_detector.sv
// Top level: configuration registers and the front end, queue and back end.
//
// Takes one sensor word per clock when nothing stalls and returns one result word per
// word taken, in order. A word passes through the multiplier register, then median and
// queue write, then the stuck check into the output register. The front end and the
// stuck checker are parted by a two-entry queue, so either side may stall without
// stopping the other at once. Echo widths are converted to distance by multiplying with
// a fixed reciprocal of 58. Configuration writes are always ready and take effect the
// next cycle; write them only while the block is idle.
module echo_median_stuck_detector #(
    parameter int FRAC_BITS = emsd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // echo_us[14:0], left_dist[26:15], right_dist[38:27], elapsed_ms[46:39], zero[47]
    input  logic [emsd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // nav_exempt[0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // front_dist[13:0], zero[15:14]
    output logic [emsd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // reverse_request[0]
    output logic [0:0]                        m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [emsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [emsd_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    emsd_pkg::t_cfg                 r_cfg;
    logic                           push_valid;
    logic                           push_ready;
    emsd_pkg::t_item                push_item;
    logic                           pop_valid;
    logic                           pop_ready;
    emsd_pkg::t_item                pop_item;
    logic [emsd_pkg::DIST_W-1:0]    front_dist;
    logic                           reverse_request;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stuck_threshold   <= emsd_pkg::THR_RESET;
            r_cfg.stuck_limit       <= emsd_pkg::LIMIT_RESET;
            r_cfg.check_interval_ms <= emsd_pkg::IVL_RESET;
        end else if (i_cfg_valid) begin
            case (emsd_pkg::t_cfg_index'(i_cfg_index))
                emsd_pkg::CFG_STUCK_THRESHOLD: begin
                    r_cfg.stuck_threshold <= i_cfg_data[emsd_pkg::THR_W-1:0];
                end
                emsd_pkg::CFG_STUCK_LIMIT: begin
                    r_cfg.stuck_limit <= i_cfg_data[emsd_pkg::LIMIT_W-1:0];
                end
                emsd_pkg::CFG_CHECK_INTERVAL_MS: begin
                    r_cfg.check_interval_ms <= i_cfg_data[emsd_pkg::IVL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    emsd_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_echo_us    (s_axis_tdata[14:0]),
        .i_left_dist  (s_axis_tdata[26:15]),
        .i_right_dist (s_axis_tdata[38:27]),
        .i_elapsed_ms (s_axis_tdata[46:39]),
        .i_nav_exempt (s_axis_tuser[0]),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    emsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    emsd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_pop_valid       (pop_valid),
        .o_pop_ready       (pop_ready),
        .i_pop_item        (pop_item),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_front_dist      (front_dist),
        .o_reverse_request (reverse_request)
    );

    assign m_axis_tdata = emsd_pkg::OUT_DATA_W'(front_dist);
    assign m_axis_tuser = reverse_request;

endmodule

>>> rtl/emsd_front.sv
// Front end: echo width to distance conversion and median-of-three filter.
module emsd_front #(
    parameter int FRAC_BITS = emsd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [emsd_pkg::ECHO_W-1:0]    i_echo_us,
    input  logic [emsd_pkg::SIDE_W-1:0]    i_left_dist,
    input  logic [emsd_pkg::SIDE_W-1:0]    i_right_dist,
    input  logic [emsd_pkg::ELAPSED_W-1:0] i_elapsed_ms,
    input  logic                           i_nav_exempt,
    output logic                           o_push_valid,
    input  logic                           i_push_ready,
    output emsd_pkg::t_item                o_push_item
);

    localparam int XW  = emsd_pkg::ECHO_W + FRAC_BITS;
    localparam int K   = XW + 6;
    localparam int MW  = K - 5;
    localparam int PW  = XW + MW;
    localparam int QW  = PW - K;
    localparam logic [MW-1:0] RECIP = MW'((2 ** K + emsd_pkg::ECHO_DIV - 1) / emsd_pkg::ECHO_DIV);
    localparam int DIST_MAX  = 2 ** emsd_pkg::DIST_W - 1;
    localparam int TOUT_FULL = emsd_pkg::TIMEOUT_CM * (2 ** FRAC_BITS);
    localparam logic [emsd_pkg::DIST_W-1:0] TOUT_DIST =
        emsd_pkg::DIST_W'((TOUT_FULL > DIST_MAX) ? DIST_MAX : TOUT_FULL);

    logic                           r_s1_valid;
    logic [PW-1:0]                  r_s1_prod;
    logic                           r_s1_tout;
    logic [emsd_pkg::SIDE_W-1:0]    r_s1_left;
    logic [emsd_pkg::SIDE_W-1:0]    r_s1_right;
    logic [emsd_pkg::ELAPSED_W-1:0] r_s1_elapsed;
    logic                           r_s1_exempt;
    logic [emsd_pkg::DIST_W-1:0]    r_hist0;
    logic [emsd_pkg::DIST_W-1:0]    r_hist1;

    logic [XW-1:0]                  scaled;
    logic [PW-1:0]                  prod;
    logic [QW-1:0]                  quot;
    logic [emsd_pkg::DIST_W-1:0]    fresh;
    logic [emsd_pkg::DIST_W-1:0]    lo_ab;
    logic [emsd_pkg::DIST_W-1:0]    hi_ab;
    logic [emsd_pkg::DIST_W-1:0]    mid_c;
    logic [emsd_pkg::DIST_W-1:0]    median;
    logic                           push;

    assign scaled = XW'(i_echo_us) << FRAC_BITS;
    assign prod   = PW'(scaled) * PW'(RECIP);
    assign quot   = r_s1_prod[PW-1:K];

    always_comb begin
        if (r_s1_tout) begin
            fresh = TOUT_DIST;
        end else if (QW'(quot) > QW'(DIST_MAX)) begin
            fresh = emsd_pkg::DIST_W'(DIST_MAX);
        end else begin
            fresh = emsd_pkg::DIST_W'(quot);
        end
    end

    always_comb begin
        lo_ab  = (fresh > r_hist0) ? r_hist0 : fresh;
        hi_ab  = (fresh > r_hist0) ? fresh : r_hist0;
        mid_c  = (hi_ab > r_hist1) ? r_hist1 : hi_ab;
        median = (lo_ab > mid_c) ? lo_ab : mid_c;
    end

    assign o_ready      = !r_s1_valid || i_push_ready;
    assign o_push_valid = r_s1_valid;
    assign push         = r_s1_valid && i_push_ready;

    always_comb begin
        o_push_item.front_dist = median;
        o_push_item.left_dist  = r_s1_left;
        o_push_item.right_dist = r_s1_right;
        o_push_item.elapsed_ms = r_s1_elapsed;
        o_push_item.nav_exempt = r_s1_exempt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_hist0    <= '0;
            r_hist1    <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (push) begin
                r_hist0 <= fresh;
                r_hist1 <= r_hist0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_prod    <= prod;
            r_s1_tout    <= (i_echo_us == '0) ||
                            (i_echo_us > emsd_pkg::ECHO_W'(emsd_pkg::ECHO_TIMEOUT_US));
            r_s1_left    <= i_left_dist;
            r_s1_right   <= i_right_dist;
            r_s1_elapsed <= i_elapsed_ms;
            r_s1_exempt  <= i_nav_exempt;
        end
    end

endmodule

>>> rtl/emsd_queue.sv
// Small first-in first-out queue between the front end and the stuck checker.
module emsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  emsd_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output emsd_pkg::t_item o_pop_item
);

    emsd_pkg::t_item                 r_mem [emsd_pkg::QUEUE_DEPTH];
    logic [emsd_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [emsd_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [emsd_pkg::QCNT_W-1:0]     r_count;
    logic [emsd_pkg::QCNT_W-1:0]     n_count;
    logic                            push;
    logic                            pop;

    assign o_push_ready = r_count != emsd_pkg::QCNT_W'(emsd_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == emsd_pkg::QPTR_W'(emsd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == emsd_pkg::QPTR_W'(emsd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

>>> rtl/emsd_back.sv
// Back end: interval timer, stuck check and registered result word.
module emsd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  emsd_pkg::t_cfg                i_cfg,
    input  logic                          i_pop_valid,
    output logic                          o_pop_ready,
    input  emsd_pkg::t_item               i_pop_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [emsd_pkg::DIST_W-1:0]   o_front_dist,
    output logic                          o_reverse_request
);

    localparam int SUM_W = emsd_pkg::TIME_W + 1;

    logic                           r_out_valid;
    logic [emsd_pkg::DIST_W-1:0]    r_out_front;
    logic                           r_out_rev;
    logic [emsd_pkg::DIST_W-1:0]    r_last_front;
    logic [emsd_pkg::SIDE_W-1:0]    r_last_left;
    logic [emsd_pkg::SIDE_W-1:0]    r_last_right;
    logic [emsd_pkg::LIMIT_W-1:0]   r_count;
    logic [emsd_pkg::TIME_W-1:0]    r_time;

    logic [emsd_pkg::LIMIT_W-1:0]   n_count;
    logic [emsd_pkg::TIME_W-1:0]    n_time;
    logic                           n_rev;
    logic [SUM_W-1:0]               time_sum;
    logic [emsd_pkg::TIME_W-1:0]    time_sat;
    logic                           check;
    logic [emsd_pkg::DIST_W-1:0]    d_front;
    logic [emsd_pkg::SIDE_W-1:0]    d_left;
    logic [emsd_pkg::SIDE_W-1:0]    d_right;
    logic                           still;
    logic [emsd_pkg::LIMIT_W-1:0]   cnt_step;
    logic                           take;

    assign o_pop_ready       = !r_out_valid || i_ready;
    assign take              = i_pop_valid && o_pop_ready;
    assign o_valid           = r_out_valid;
    assign o_front_dist      = r_out_front;
    assign o_reverse_request = r_out_rev;

    always_comb begin
        time_sum = SUM_W'(r_time) + SUM_W'(i_pop_item.elapsed_ms);
        time_sat = time_sum[SUM_W-1] ? '1 : time_sum[emsd_pkg::TIME_W-1:0];
        check    = time_sat > emsd_pkg::TIME_W'(i_cfg.check_interval_ms);

        d_front = (i_pop_item.front_dist > r_last_front) ?
                  i_pop_item.front_dist - r_last_front : r_last_front - i_pop_item.front_dist;
        d_left  = (i_pop_item.left_dist > r_last_left) ?
                  i_pop_item.left_dist - r_last_left : r_last_left - i_pop_item.left_dist;
        d_right = (i_pop_item.right_dist > r_last_right) ?
                  i_pop_item.right_dist - r_last_right : r_last_right - i_pop_item.right_dist;
        still   = (d_front < emsd_pkg::DIST_W'(i_cfg.stuck_threshold)) &&
                  (d_left  < emsd_pkg::SIDE_W'(i_cfg.stuck_threshold)) &&
                  (d_right < emsd_pkg::SIDE_W'(i_cfg.stuck_threshold));

        if (still) begin
            cnt_step = (r_count == '1) ? r_count : r_count + 1'b1;
        end else begin
            cnt_step = '0;
        end

        n_count = r_count;
        n_rev   = 1'b0;
        n_time  = time_sat;
        if (check) begin
            n_time = '0;
            if (!i_pop_item.nav_exempt) begin
                if (cnt_step >= i_cfg.stuck_limit) begin
                    n_rev   = 1'b1;
                    n_count = '0;
                end else begin
                    n_count = cnt_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_front <= '0;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_count      <= '0;
            r_time       <= '0;
        end else begin
            if (o_pop_ready) begin
                r_out_valid <= i_pop_valid;
            end
            if (take) begin
                r_count <= n_count;
                r_time  <= n_time;
                if (check) begin
                    r_last_front <= i_pop_item.front_dist;
                    r_last_left  <= i_pop_item.left_dist;
                    r_last_right <= i_pop_item.right_dist;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_front <= i_pop_item.front_dist;
            r_out_rev   <= n_rev;
        end
    end

endmodule

>>> test/echo_median_stuck_detector_tb.sv
// Self-checking stream testbench for the echo median stuck detector.
`timescale 1ns / 1ps

module echo_median_stuck_detector_tb;

    localparam int FRAC          = emsd_pkg::DEFAULT_FRAC_BITS;
    localparam int DIST_SAT      = 16383;
    localparam int MS_SAT        = 2047;
    localparam int STILL_SAT     = 7;
    localparam int N_DIRECTED    = 20;
    localparam int N_PHASES      = 8;
    localparam int WORDS_PER_SET = 110;
    localparam int LONG_HOLD     = 400;
    localparam int WATCHDOG_MAX  = 4000;

    typedef struct packed {
        logic [emsd_pkg::ECHO_W-1:0]    echo_us;
        logic [emsd_pkg::SIDE_W-1:0]    left_dist;
        logic [emsd_pkg::SIDE_W-1:0]    right_dist;
        logic [emsd_pkg::ELAPSED_W-1:0] elapsed_ms;
        logic                           nav_exempt;
    } t_sensor;

    typedef struct packed {
        logic [emsd_pkg::DIST_W-1:0] front_dist;
        logic                        reverse_request;
    } t_result;

    typedef struct packed {
        t_sensor word;
        logic    typed;
        t_result want;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [emsd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [emsd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]                      m_axis_tuser;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [emsd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [emsd_pkg::CFG_DAT_W-1:0]  i_cfg_data = '0;

    echo_median_stuck_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // detector copy: settings and state
    logic [emsd_pkg::THR_W-1:0]   cfg_thr = emsd_pkg::THR_RESET;
    logic [emsd_pkg::LIMIT_W-1:0] cfg_lim = emsd_pkg::LIMIT_RESET;
    logic [emsd_pkg::IVL_W-1:0]   cfg_ivl = emsd_pkg::IVL_RESET;
    logic [emsd_pkg::DIST_W-1:0]  hist_prev = '0;
    logic [emsd_pkg::DIST_W-1:0]  hist_prev2 = '0;
    logic [emsd_pkg::DIST_W-1:0]  chk_front = '0;
    logic [emsd_pkg::SIDE_W-1:0]  chk_left = '0;
    logic [emsd_pkg::SIDE_W-1:0]  chk_right = '0;
    logic [emsd_pkg::LIMIT_W-1:0] still_count = '0;
    logic [emsd_pkg::TIME_W-1:0]  ms_accum = '0;

    t_result awaited_results [$];
    int      err_count = 0;
    int      words_sent = 0;
    int      results_seen = 0;
    int      reverse_seen = 0;
    int      idle_cycles = 0;
    logic    calm = 1'b0;
    logic    hold_long = 1'b0;
    logic    long_done = 1'b0;
    int      rx_wait = 0;

    // scene that stationary words hover around
    int scene_echo = 1160;
    int scene_left = 100;
    int scene_right = 200;
    int scene_jit = 10;

    function automatic int unsigned absd(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic step_detector(input t_sensor w, output t_result r);
        int unsigned fresh;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned t;
        int unsigned acc;
        if (w.echo_us == 0 || w.echo_us > emsd_pkg::ECHO_TIMEOUT_US) begin
            fresh = emsd_pkg::TIMEOUT_CM << FRAC;
        end else begin
            fresh = (int'(w.echo_us) << FRAC) / emsd_pkg::ECHO_DIV;
        end
        if (fresh > DIST_SAT) fresh = DIST_SAT;
        a = fresh;
        b = hist_prev;
        c = hist_prev2;
        if (a > b) begin
            t = a; a = b; b = t;
        end
        if (b > c) b = c;
        if (a > b) b = a;
        r.front_dist = b[emsd_pkg::DIST_W-1:0];
        r.reverse_request = 1'b0;
        hist_prev2 = hist_prev;
        hist_prev = fresh[emsd_pkg::DIST_W-1:0];
        acc = ms_accum + w.elapsed_ms;
        if (acc > MS_SAT) acc = MS_SAT;
        ms_accum = acc[emsd_pkg::TIME_W-1:0];
        if (ms_accum > cfg_ivl) begin
            if (!w.nav_exempt) begin
                if (absd(b, chk_front) < cfg_thr && absd(w.left_dist, chk_left) < cfg_thr &&
                    absd(w.right_dist, chk_right) < cfg_thr) begin
                    if (still_count < STILL_SAT) still_count = still_count + 1'b1;
                end else begin
                    still_count = '0;
                end
                if (still_count >= cfg_lim) begin
                    r.reverse_request = 1'b1;
                    still_count = '0;
                end
            end
            chk_front = b[emsd_pkg::DIST_W-1:0];
            chk_left = w.left_dist;
            chk_right = w.right_dist;
            ms_accum = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
        err_count++;
    endtask

    // hold the word until taken, then predict it
    task automatic push_sensor_word(input t_sensor w, input logic typed, input t_result want);
        t_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, w.elapsed_ms, w.right_dist, w.left_dist, w.echo_us};
        s_axis_tuser <= w.nav_exempt;
        do @(posedge i_clk); while (!s_axis_tready);
        step_detector(w, r);
        awaited_results.push_back(typed ? want : r);
        words_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic load_settings(input int thr, input int lim, input int ivl);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= emsd_pkg::CFG_STUCK_THRESHOLD;
        i_cfg_data <= emsd_pkg::CFG_DAT_W'(thr);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_thr = emsd_pkg::THR_W'(thr);
        i_cfg_index <= emsd_pkg::CFG_STUCK_LIMIT;
        i_cfg_data <= emsd_pkg::CFG_DAT_W'(lim);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_lim = emsd_pkg::LIMIT_W'(lim);
        i_cfg_index <= emsd_pkg::CFG_CHECK_INTERVAL_MS;
        i_cfg_data <= emsd_pkg::CFG_DAT_W'(ivl);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_ivl = emsd_pkg::IVL_W'(ivl);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic int clamp(input int v, input int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic t_sensor make_word();
        t_sensor w;
        int      pick;
        int      edges [7];
        edges = '{0, 1, 57, 58, 25000, 25001, 32767};
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            scene_echo = $urandom_range(1, 25000);
            scene_left = $urandom_range(0, 4095);
            scene_right = $urandom_range(0, 4095);
            scene_jit = $urandom_range(0, 60);
        end
        if (pick < 72) begin
            w.echo_us = emsd_pkg::ECHO_W'(clamp(scene_echo +
                                                $urandom_range(0, 2 * scene_jit) -
                                                scene_jit, 25000));
            w.left_dist = emsd_pkg::SIDE_W'(clamp(scene_left +
                                                  $urandom_range(0, 2 * scene_jit) -
                                                  scene_jit, 4095));
            w.right_dist = emsd_pkg::SIDE_W'(clamp(scene_right +
                                                   $urandom_range(0, 2 * scene_jit) -
                                                   scene_jit, 4095));
        end else if (pick < 87) begin
            w.echo_us = emsd_pkg::ECHO_W'($urandom);
            w.left_dist = emsd_pkg::SIDE_W'($urandom);
            w.right_dist = emsd_pkg::SIDE_W'($urandom);
        end else begin
            w.echo_us = emsd_pkg::ECHO_W'(edges[$urandom_range(0, 6)]);
            w.left_dist = $urandom_range(0, 1) ? emsd_pkg::SIDE_W'(4095) : emsd_pkg::SIDE_W'(0);
            w.right_dist = $urandom_range(0, 1) ? emsd_pkg::SIDE_W'(4095) : emsd_pkg::SIDE_W'(0);
        end
        case ($urandom_range(0, 9))
            0: w.elapsed_ms = '0;
            1: w.elapsed_ms = '1;
            default: w.elapsed_ms = emsd_pkg::ELAPSED_W'($urandom);
        endcase
        w.nav_exempt = ($urandom_range(0, 6) == 0);
        return w;
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end else if (hold_long && !long_done) begin
            long_done <= 1'b1;
            rx_wait <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            rx_wait <= $urandom_range(1, 17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser[0]) reverse_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected word, front_dist",
                                m_axis_tdata[emsd_pkg::DIST_W-1:0], -1);
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[emsd_pkg::DIST_W-1:0] !== want.front_dist)
                    report_mismatch("front_dist", m_axis_tdata[emsd_pkg::DIST_W-1:0],
                                    want.front_dist);
                if (m_axis_tuser[0] !== want.reverse_request)
                    report_mismatch("reverse_request", m_axis_tuser[0], want.reverse_request);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row dir_rows [N_DIRECTED];
        int       set_thr [N_PHASES];
        int       set_lim [N_PHASES];
        int       set_ivl [N_PHASES];
        t_result  none;
        none = '0;

        dir_rows[0]  = '{'{15'd0,     12'd0,    12'd0,    8'd0,   1'b0}, 1'b1, '{14'd0, 1'b0}};
        dir_rows[1]  = '{'{15'd32767, 12'd4095, 12'd4095, 8'd255, 1'b1}, 1'b1,
                         '{14'd15984, 1'b0}};
        dir_rows[2]  = '{'{15'd25000, 12'd4095, 12'd4095, 8'd255, 1'b1}, 1'b1,
                         '{14'd15984, 1'b0}};
        dir_rows[3]  = '{'{15'd25001, 12'd4095, 12'd4095, 8'd255, 1'b0}, 1'b1,
                         '{14'd15984, 1'b0}};
        dir_rows[4]  = '{'{15'd1,     12'd4095, 12'd4095, 8'd255, 1'b0}, 1'b1,
                         '{14'd6896, 1'b0}};
        dir_rows[5]  = '{'{15'd1160, 12'd100, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[6]  = '{'{15'd1160, 12'd100, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[7]  = '{'{15'd1160, 12'd100, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[8]  = '{'{15'd1160, 12'd100, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[9]  = '{'{15'd1160, 12'd100, 12'd200, 8'd255, 1'b1}, 1'b0, none};
        dir_rows[10] = '{'{15'd1160, 12'd100, 12'd200, 8'd255, 1'b1}, 1'b0, none};
        dir_rows[11] = '{'{15'd1160, 12'd147, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[12] = '{'{15'd1160, 12'd147, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[13] = '{'{15'd1160, 12'd195, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[14] = '{'{15'd1160, 12'd195, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[15] = '{'{15'd58,   12'd195, 12'd200, 8'd0,   1'b0}, 1'b0, none};
        dir_rows[16] = '{'{15'd57,   12'd195, 12'd200, 8'd0,   1'b0}, 1'b0, none};
        dir_rows[17] = '{'{15'd1200, 12'd195, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[18] = '{'{15'd1160, 12'd195, 12'd200, 8'd255, 1'b0}, 1'b0, none};
        dir_rows[19] = '{'{15'd1160, 12'd195, 12'd200, 8'd255, 1'b0}, 1'b0, none};

        set_thr = '{1023, 0,    1023, 300, 0, 1023, 0, 48};
        set_lim = '{1,    7,    0,    7,   0, 2,    0, 2};
        set_ivl = '{0,    1023, 100,  0,   0, 255,  0, 500};
        set_thr[4] = $urandom_range(0, 1023);
        set_lim[4] = $urandom_range(0, 7);
        set_ivl[4] = $urandom_range(0, 1023);
        set_thr[6] = $urandom_range(0, 1023);
        set_lim[6] = $urandom_range(0, 7);
        set_ivl[6] = $urandom_range(0, 400);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            push_sensor_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            load_settings(set_thr[p], set_lim[p], set_ivl[p]);
            if (p == 0) hold_long <= 1'b1;
            if (p == N_PHASES - 1) calm <= 1'b1;
            for (int k = 0; k < WORDS_PER_SET; k++)
                push_sensor_word(make_word(), 1'b0, none);
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        $display("Sent %0d sensor words through %0d register settings plus reset defaults.",
                 words_sent, N_PHASES);
        $display("Checked %0d result words, %0d of them reverse pulses.",
                 results_seen, reverse_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
